// ===== src/sfc_pkg.sv =====
// Shared types and register indexes of the sphere frustum culling block.
`timescale 1ns / 1ps
`default_nettype none
package sfc_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;
	localparam int DIST_W     = 31;
	localparam int SIZE_W     = 13;

	localparam logic [CFG_IDX_W-1:0] REG_NEAR_DIST     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FAR_DIST      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TAN_HALF_FOV  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd4;

	typedef struct packed {
		logic signed [31:0] hp;
		logic signed [31:0] hq;
		logic signed [31:0] vp;
		logic signed [31:0] vq;
	} sfc_normals_t;

endpackage
`default_nettype wire

// ===== src/sfc_normals.sv =====
// Sequencer that derives the side plane normals with a shared square root and divider.
`timescale 1ns / 1ps
`default_nettype none
module sfc_normals import sfc_pkg::*; #(
	parameter int COORD_FRAC_BITS  = 16,
	parameter int NORMAL_FRAC_BITS = 30
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                recalc,
	input  wire logic [DIST_W-1:0]   tan_half_fov,
	input  wire logic [SIZE_W-1:0]   screen_width,
	input  wire logic [SIZE_W-1:0]   screen_height,
	output logic                     busy,
	output sfc_normals_t             normals
);

	localparam int P_W  = SIZE_W + COORD_FRAC_BITS;
	localparam int Q_W  = DIST_W + SIZE_W;
	localparam int PQ_W = (P_W > Q_W) ? P_W : Q_W;
	localparam int DW   = 32 + NORMAL_FRAC_BITS;
	localparam int CW   = $clog2(DW);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_LOAD  = 4'd1;
	localparam logic [3:0] ST_NORM  = 4'd2;
	localparam logic [3:0] ST_SQP   = 4'd3;
	localparam logic [3:0] ST_SQQ   = 4'd4;
	localparam logic [3:0] ST_SUM   = 4'd5;
	localparam logic [3:0] ST_ROOT  = 4'd6;
	localparam logic [3:0] ST_DIVP  = 4'd7;
	localparam logic [3:0] ST_DIVQ  = 4'd8;
	localparam logic [3:0] ST_STORE = 4'd9;

	logic [3:0]      state_q;
	logic            pair_q;
	logic [PQ_W-1:0] p_q, q_q;
	logic [61:0]     pp_q, qq_q;
	logic [63:0]     v_q, res_q, bit_q;
	logic [4:0]      root_cnt_q;
	logic [31:0]     n_q;
	logic [DW-1:0]   dvd_q, quot_q;
	logic [32:0]     rem_q;
	logic [CW-1:0]   div_cnt_q;
	logic [31:0]     cp_q, cq_q;

	logic [63:0]     root_try;
	logic [32:0]     rem_sh;
	logic [32:0]     rem_diff;
	logic            rem_ge;
	logic [31:0]     n_next;
	logic [DW-1:0]   dvd_p, dvd_q_init;
	logic [DW-1:0]   quot_next;

	assign root_try  = res_q + bit_q;
	assign rem_sh    = {rem_q[31:0], dvd_q[DW-1]};
	assign rem_diff  = rem_sh - {1'b0, n_q};
	assign rem_ge    = rem_sh >= {1'b0, n_q};
	assign quot_next = {quot_q[DW-2:0], rem_ge};
	assign n_next    = (v_q >= root_try) ? (res_q[32:1] + bit_q[31:0]) : res_q[32:1];
	assign dvd_p      = (DW'(p_q[30:0]) << NORMAL_FRAC_BITS) + DW'(n_next[31:1]);
	assign dvd_q_init = (DW'(q_q[30:0]) << NORMAL_FRAC_BITS) + DW'(n_q[31:1]);
	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pair_q  <= 1'b0;
			normals <= '0;
		end else if (recalc) begin
			state_q <= ST_LOAD;
			pair_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					state_q <= ST_IDLE;
				end
				ST_LOAD: begin
					state_q <= ST_NORM;
				end
				ST_NORM: begin
					if ((p_q >> 31) == '0 && (q_q >> 31) == '0) begin
						state_q <= ST_SQP;
					end
				end
				ST_SQP: begin
					state_q <= ST_SQQ;
				end
				ST_SQQ: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (root_cnt_q == '0) begin
						state_q <= (n_next == '0) ? ST_STORE : ST_DIVP;
					end
				end
				ST_DIVP: begin
					if (div_cnt_q == '0) begin
						state_q <= ST_DIVQ;
					end
				end
				ST_DIVQ: begin
					if (div_cnt_q == '0) begin
						state_q <= ST_STORE;
					end
				end
				ST_STORE: begin
					if (pair_q) begin
						normals.vp <= cp_q;
						normals.vq <= cq_q;
						state_q    <= ST_IDLE;
					end else begin
						normals.hp <= cp_q;
						normals.hq <= cq_q;
						pair_q     <= 1'b1;
						state_q    <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				if (pair_q) begin
					p_q <= PQ_W'(1) << COORD_FRAC_BITS;
					q_q <= PQ_W'(tan_half_fov);
				end else begin
					p_q <= PQ_W'(screen_height) << COORD_FRAC_BITS;
					q_q <= PQ_W'(tan_half_fov) * PQ_W'(screen_width);
				end
			end
			ST_NORM: begin
				if ((p_q >> 31) != '0 || (q_q >> 31) != '0) begin
					p_q <= p_q >> 1;
					q_q <= q_q >> 1;
				end
			end
			ST_SQP: begin
				pp_q <= p_q[30:0] * p_q[30:0];
			end
			ST_SQQ: begin
				qq_q <= q_q[30:0] * q_q[30:0];
			end
			ST_SUM: begin
				v_q        <= 64'(pp_q) + 64'(qq_q);
				res_q      <= '0;
				bit_q      <= 64'd1 << 62;
				root_cnt_q <= 5'd31;
			end
			ST_ROOT: begin
				if (v_q >= root_try) begin
					v_q   <= v_q - root_try;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q      <= bit_q >> 2;
				root_cnt_q <= root_cnt_q - 5'd1;
				if (root_cnt_q == '0) begin
					n_q       <= n_next;
					cp_q      <= '0;
					cq_q      <= '0;
					rem_q     <= '0;
					dvd_q     <= dvd_p;
					div_cnt_q <= CW'(DW - 1);
				end
			end
			ST_DIVP: begin
				quot_q <= quot_next;
				if (div_cnt_q == '0) begin
					cp_q      <= quot_next[31:0];
					rem_q     <= '0;
					dvd_q     <= dvd_q_init;
					div_cnt_q <= CW'(DW - 1);
				end else begin
					rem_q     <= rem_ge ? rem_diff : rem_sh;
					dvd_q     <= dvd_q << 1;
					div_cnt_q <= div_cnt_q - CW'(1);
				end
			end
			ST_DIVQ: begin
				rem_q     <= rem_ge ? rem_diff : rem_sh;
				quot_q    <= quot_next;
				dvd_q     <= dvd_q << 1;
				div_cnt_q <= div_cnt_q - CW'(1);
				if (div_cnt_q == '0) begin
					cq_q <= quot_next[31:0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== src/sfc_cull_pipe.sv =====
// Four-stage pipeline that runs the depth and side plane tests on one sphere per cycle.
`timescale 1ns / 1ps
`default_nettype none
module sfc_cull_pipe import sfc_pkg::*; #(
	parameter int NORMAL_FRAC_BITS = 30
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic signed [31:0] center_x,
	input  wire logic signed [31:0] center_y,
	input  wire logic signed [31:0] center_z,
	input  wire logic [30:0]        sphere_radius,
	input  wire logic [DIST_W-1:0]  near_dist,
	input  wire logic [DIST_W-1:0]  far_dist,
	input  wire sfc_normals_t       normals,
	output logic                    done,
	output logic                    culled
);

	logic               valid_s1, valid_s2, valid_s3;
	logic signed [31:0] x_s1, y_s1, z_s1;
	logic [30:0]        rad_s1, rad_s2;
	logic signed [63:0] hx_s2, hz_s2, vy_s2, vz_s2;
	logic               depth_cull_s2;
	logic               cull_s3;

	logic signed [33:0] depth;
	logic signed [33:0] near_lim;
	logic signed [33:0] far_lim;
	logic signed [65:0] rad_scaled;
	logic signed [65:0] d_left, d_right, d_top, d_bottom;

	assign depth    = -34'(z_s1);
	assign near_lim = $signed(34'(near_dist)) - $signed(34'(rad_s1));
	assign far_lim  = $signed(34'(far_dist)) + $signed(34'(rad_s1));

	assign rad_scaled = $signed(66'(rad_s2) << NORMAL_FRAC_BITS);
	assign d_left   = 66'(hz_s2) - 66'(hx_s2);
	assign d_right  = 66'(hz_s2) + 66'(hx_s2);
	assign d_top    = 66'(vz_s2) + 66'(vy_s2);
	assign d_bottom = 66'(vz_s2) - 66'(vy_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done     <= 1'b0;
			culled   <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done     <= valid_s3;
			culled   <= valid_s3 & cull_s3;
		end
	end

	always_ff @(posedge clk) begin
		x_s1          <= center_x;
		y_s1          <= center_y;
		z_s1          <= center_z;
		rad_s1        <= sphere_radius;
		rad_s2        <= rad_s1;
		hx_s2         <= normals.hp * x_s1;
		hz_s2         <= normals.hq * z_s1;
		vy_s2         <= normals.vp * y_s1;
		vz_s2         <= normals.vq * z_s1;
		depth_cull_s2 <= (depth < near_lim) || (depth > far_lim);
		cull_s3       <= depth_cull_s2 || (d_left > rad_scaled) || (d_right > rad_scaled) ||
				(d_top > rad_scaled) || (d_bottom > rad_scaled);
	end

endmodule
`default_nettype wire

// ===== src/sphere_frustum_cull.sv =====
// Top level of the sphere frustum culling block: registers, normal unit and test pipeline.
// The block takes one sphere every cycle while busy is low and raises done with the culled
// bit for one cycle once the sphere has passed the pipeline registers; results cannot be held
// off. Every write to a known register restarts the derivation of the side plane normals,
// during which busy is high: per pair of normals it loads the operands, shifts them down until
// they fit in 31 bits, squares and sums them, takes the bit-serial square root and runs two
// divisions, skipped when the root is zero, before it stores the pair, all on the shared
// iterative square root and divider.
`timescale 1ns / 1ps
`default_nettype none
module sphere_frustum_cull import sfc_pkg::*; #(
	parameter int COORD_FRAC_BITS  = 16,
	parameter int NORMAL_FRAC_BITS = 30
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic signed [31:0]    center_x,
	input  wire logic signed [31:0]    center_y,
	input  wire logic signed [31:0]    center_z,
	input  wire logic [30:0]           sphere_radius,
	output logic                       done,
	output logic                       culled,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [DIST_W-1:0] near_dist_q, far_dist_q, tan_half_fov_q;
	logic [SIZE_W-1:0] screen_width_q, screen_height_q;
	logic              recalc_q;
	sfc_normals_t      normals;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_dist_q     <= 31'd65536;
			far_dist_q      <= 31'd65536000;
			tan_half_fov_q  <= 31'd65536;
			screen_width_q  <= 13'd640;
			screen_height_q <= 13'd480;
			recalc_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_NEAR_DIST: begin
						near_dist_q <= cfg_data;
						recalc_q    <= 1'b1;
					end
					REG_FAR_DIST: begin
						far_dist_q <= cfg_data;
						recalc_q   <= 1'b1;
					end
					REG_TAN_HALF_FOV: begin
						tan_half_fov_q <= cfg_data;
						recalc_q       <= 1'b1;
					end
					REG_SCREEN_WIDTH: begin
						screen_width_q <= cfg_data[SIZE_W-1:0];
						recalc_q       <= 1'b1;
					end
					REG_SCREEN_HEIGHT: begin
						screen_height_q <= cfg_data[SIZE_W-1:0];
						recalc_q        <= 1'b1;
					end
					default: begin
						recalc_q <= 1'b0;
					end
				endcase
			end else begin
				recalc_q <= 1'b0;
			end
		end
	end

	logic unit_busy;

	assign busy = unit_busy | recalc_q;

	sfc_normals #(
		.COORD_FRAC_BITS (COORD_FRAC_BITS),
		.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
	) u_normals (
		.clk          (clk),
		.arst_n       (arst_n),
		.recalc       (recalc_q),
		.tan_half_fov (tan_half_fov_q),
		.screen_width (screen_width_q),
		.screen_height(screen_height_q),
		.busy         (unit_busy),
		.normals      (normals)
	);

	sfc_cull_pipe #(
		.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
	) u_pipe (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (start & ~busy),
		.center_x     (center_x),
		.center_y     (center_y),
		.center_z     (center_z),
		.sphere_radius(sphere_radius),
		.near_dist    (near_dist_q),
		.far_dist     (far_dist_q),
		.normals      (normals),
		.done         (done),
		.culled       (culled)
	);

endmodule
`default_nettype wire

// ===== src/sfc_checker.sv =====
// Port-level checker of the sphere frustum culling block and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sfc_checker import sfc_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 start,
	input wire logic                 busy,
	input wire logic                 done,
	input wire logic                 culled,
	input wire logic                 cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index
);

	a_beat_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##4 done)
		else $error("An accepted beat produced no result four cycles later.");

	a_result_has_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4))
		else $error("A result appeared without an accepted beat.");

	a_write_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == REG_NEAR_DIST || cfg_index == REG_FAR_DIST ||
		cfg_index == REG_TAN_HALF_FOV || cfg_index == REG_SCREEN_WIDTH ||
		cfg_index == REG_SCREEN_HEIGHT) |=> busy)
		else $error("A register write did not start the normal update.");

	a_culled_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> !culled)
		else $error("Culled was high outside a result cycle.");

endmodule

bind sphere_frustum_cull sfc_checker u_sfc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.culled   (culled),
	.cfg_we   (cfg_we),
	.cfg_index(cfg_index)
);
`default_nettype wire

// ===== dv/sphere_frustum_cull_test.sv =====
// Self-checking testbench for the sphere frustum culling block with its own cull predictor.
`timescale 1ns / 1ps
`default_nettype none
module sphere_frustum_cull_test;
	import sfc_pkg::*;

	localparam int COORD_FB  = 16;
	localparam int NORMAL_FB = 30;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [30:0]        r;
	} sphere_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done, culled;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	sphere_t beat_cur = '0;

	sphere_t pending_spheres[$];
	bit cull_expected[$];
	int idle_pct = 0;
	int errors = 0;
	int accepted = 0;
	int checked = 0;
	int culled_seen = 0;
	int reg_writes = 0;
	longint cycles = 0;

	logic [30:0] near_q, far_q, tan_q;
	logic [12:0] width_q, height_q;
	sfc_normals_t nrm;

	sphere_frustum_cull u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.center_x(beat_cur.x), .center_y(beat_cur.y), .center_z(beat_cur.z),
		.sphere_radius(beat_cur.r), .done(done), .culled(culled),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	task automatic unit_pair(input longint unsigned p, input longint unsigned q,
			output logic signed [31:0] cp, output logic signed [31:0] cq);
		longint unsigned n;
		while (p >= (64'd1 << 31) || q >= (64'd1 << 31)) begin
			p >>= 1;
			q >>= 1;
		end
		n = floor_sqrt(p * p + q * q);
		if (n == 0) begin
			cp = '0;
			cq = '0;
		end else begin
			cp = 32'(((p << NORMAL_FB) + n / 2) / n);
			cq = 32'(((q << NORMAL_FB) + n / 2) / n);
		end
	endtask

	task automatic shadow_write(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] val);
		case (idx)
			REG_NEAR_DIST: near_q = val;
			REG_FAR_DIST: far_q = val;
			REG_TAN_HALF_FOV: tan_q = val;
			REG_SCREEN_WIDTH: width_q = val[12:0];
			REG_SCREEN_HEIGHT: height_q = val[12:0];
			default: return;
		endcase
		unit_pair(longint'(height_q) << COORD_FB, longint'(tan_q) * longint'(width_q),
			nrm.hp, nrm.hq);
		unit_pair(64'd1 << COORD_FB, longint'(tan_q), nrm.vp, nrm.vq);
	endtask

	function automatic bit sphere_culled(sphere_t s);
		longint x, y, z, rad, rs;
		x = longint'(s.x);
		y = longint'(s.y);
		z = longint'(s.z);
		rad = longint'({1'b0, s.r});
		rs = rad <<< NORMAL_FB;
		if (-z < longint'({1'b0, near_q}) - rad || -z > longint'({1'b0, far_q}) + rad)
			return 1'b1;
		if (-x * longint'(nrm.hp) + z * longint'(nrm.hq) > rs) return 1'b1;
		if (y * longint'(nrm.vp) + z * longint'(nrm.vq) > rs) return 1'b1;
		if (x * longint'(nrm.hp) + z * longint'(nrm.hq) > rs) return 1'b1;
		if (-y * longint'(nrm.vp) + z * longint'(nrm.vq) > rs) return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
		if (v < -64'sh80000000) return 32'sh80000000;
		return 32'(v);
	endfunction

	function automatic sphere_t random_sphere();
		sphere_t s;
		longint d, span;
		if ($urandom_range(9) < 2) begin
			s.x = $urandom;
			s.y = $urandom;
			s.z = $urandom;
			s.r = 31'($urandom);
			return s;
		end
		span = longint'({1'b0, far_q}) * 5 / 4 + 65536;
		if (span > 64'h7FFFFFFF) span = 64'h7FFFFFFF;
		d = longint'($urandom_range(32'(span)));
		s.z = clamp32(-d);
		span = 2 * d + 65536;
		if (span > 64'h7FFFFFFF) span = 64'h7FFFFFFF;
		s.x = clamp32(longint'($urandom_range(32'(span))) * ($urandom_range(1) ? 1 : -1));
		s.y = clamp32(longint'($urandom_range(32'(span))) * ($urandom_range(1) ? 1 : -1));
		span = d / 4 + 65536;
		if (span > 64'h7FFFFFFF) span = 64'h7FFFFFFF;
		s.r = 31'($urandom_range(32'(span)));
		if ($urandom_range(15) == 0) s.r = 31'($urandom);
		return s;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[sphere_frustum_cull] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			cull_expected.push_back(sphere_culled(beat_cur));
			accepted <= accepted + 1;
		end
		if (!start || !busy) begin
			if (arst_n && pending_spheres.size() > 0 && $urandom_range(99) >= idle_pct) begin
				beat_cur <= pending_spheres.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (cull_expected.size() == 0) begin
				$error("culled: result beat with nothing expected (actual %0b)", culled);
				errors++;
			end else begin
				bit want;
				want = cull_expected.pop_front();
				checked++;
				if (culled) culled_seen++;
				if (culled !== want) begin
					$error("culled: expected %0b, actual %0b", want, culled);
					errors++;
				end
			end
		end
	end

	task automatic drain();
		while (pending_spheres.size() > 0 || start || cull_expected.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		shadow_write(idx, val);
		reg_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic set_view(input logic [30:0] nd, input logic [30:0] fd, input logic [30:0] tf,
			input logic [30:0] w, input logic [30:0] h);
		write_reg(REG_NEAR_DIST, nd);
		write_reg(REG_FAR_DIST, fd);
		write_reg(REG_TAN_HALF_FOV, tf);
		write_reg(REG_SCREEN_WIDTH, w);
		write_reg(REG_SCREEN_HEIGHT, h);
	endtask

	task automatic random_phase(input int pct, input int n);
		idle_pct = pct;
		repeat (n) pending_spheres.push_back(random_sphere());
		drain();
	endtask

	task automatic push_sphere(input longint x, input longint y, input longint z,
			input logic [30:0] r);
		sphere_t s;
		s.x = clamp32(x);
		s.y = clamp32(y);
		s.z = clamp32(z);
		s.r = r;
		pending_spheres.push_back(s);
	endtask

	initial begin
		near_q = 31'd65536;
		far_q = 31'd65536000;
		tan_q = 31'd65536;
		width_q = 13'd640;
		height_q = 13'd480;
		nrm = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Before any register write the side normals are zero: only depth can cull.
		idle_pct = 13;
		push_sphere(0, 0, -65536, 0);
		push_sphere(0, 0, -65535, 0);
		push_sphere(0, 0, -65536000, 0);
		push_sphere(0, 0, -65536001, 0);
		push_sphere(64'sh7FFFFFFF, 64'sh7FFFFFFF, -655360, 0);
		push_sphere(-64'sh80000000, -64'sh80000000, -655360, 0);
		push_sphere(0, 0, 64'sh7FFFFFFF, 31'h7FFFFFFF);
		push_sphere(0, 0, -64'sh80000000, 31'h7FFFFFFF);
		push_sphere(0, 0, 0, 31'd65536);
		push_sphere(-1, -1, -1, 31'd1);
		drain();

		set_view(31'd65536, 31'd65536000, 31'd65536, 31'd640, 31'd480);
		push_sphere(655360, 0, -655360, 0);
		push_sphere(655361 * 4 / 3, 0, -655360, 0);
		push_sphere(0, 655361, -655360, 0);
		push_sphere(0, -655361, -655360, 31'd65536);
		push_sphere(-900000, 0, -655360, 31'd1);
		push_sphere(64'sh7FFFFFFF, -64'sh80000000, -64'sh80000000, 31'h7FFFFFFF);
		push_sphere(0, 0, -131072, 31'd0);
		drain();
		random_phase(13, 180);

		set_view(31'd1, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'd8191, 31'd1);
		random_phase(13, 180);
		set_view(31'd0, 31'd1, 31'd1, 31'd1, 31'd8191);
		random_phase(13, 150);

		// A zero height with a zero width, then with a zero tangent, leaves a pair of
		// normals at zero.
		write_reg(REG_NEAR_DIST, 31'd32768);
		write_reg(REG_FAR_DIST, 31'd6553600);
		write_reg(REG_SCREEN_WIDTH, 31'd0);
		write_reg(REG_SCREEN_HEIGHT, 31'd0);
		random_phase(82, 120);
		write_reg(REG_TAN_HALF_FOV, 31'd0);
		random_phase(82, 120);

		set_view(31'($urandom_range(1, 1 << 22)), 31'($urandom_range(1 << 23, 1 << 30)),
			31'($urandom_range(1, 1 << 19)), 31'($urandom_range(1, 4096)),
			31'($urandom_range(1, 4096)));
		write_reg(REG_UNUSED, 31'($urandom));
		random_phase(82, 200);

		set_view(31'($urandom_range(1, 1 << 20)), 31'($urandom_range(1 << 21, 1 << 31)),
			31'($urandom), 31'($urandom_range(1, 4096)), 31'($urandom_range(1, 4096)));
		random_phase(0, 220);
		set_view(31'd65536, 31'd65536000, 31'd65536, 31'd4096, 31'd4096);
		random_phase(0, 200);

		drain();
		$display("Covered %0d spheres (%0d checked, %0d culled) over %0d register writes,",
			accepted, checked, culled_seen, reg_writes);
		$display("including zero normals, zero near distance and extreme view settings.");
		if (errors == 0 && cull_expected.size() == 0) begin
			$display("[sphere_frustum_cull] OK");
		end else begin
			$display("[sphere_frustum_cull] ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
src/sfc_pkg.sv
src/sfc_normals.sv
src/sfc_cull_pipe.sv
src/sphere_frustum_cull.sv
src/sfc_checker.sv
dv/sphere_frustum_cull_test.sv
